@@ hw/rtl/mdbr_pkg.sv @@
`timescale 1ns / 1ps

package mdbr_pkg;

	localparam int BUTTONS    = 8;
	localparam int COUNT_BITS = 16;
	localparam int IDX_W      = 3;
	localparam int LEVEL_W    = 8;
	localparam int MASK_W     = 8;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX        = '1;
	localparam logic [COUNT_BITS-1:0] DEBOUNCE_DEFAULT = COUNT_BITS'(10);
	localparam logic [COUNT_BITS-1:0] REPEAT_DEFAULT   = COUNT_BITS'(250);

	typedef enum logic [1:0] {
		PH_IDLE        = 2'd0,
		PH_PRESS_DEB   = 2'd1,
		PH_PRESSED     = 2'd2,
		PH_RELEASE_DEB = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PRESSED  = 2'd0,
		KIND_KEPT     = 2'd1,
		KIND_RELEASED = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		REG_ACTIVE_HIGH    = 3'd0,
		REG_PRESS_REPORT   = 3'd1,
		REG_RELEASE_REPORT = 3'd2,
		REG_DEBOUNCE       = 3'd3,
		REG_REPEAT         = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] index;
		kind_t            kind;
		logic             last;
	} slot_t;

	typedef struct packed {
		logic active_high;
		logic report_press;
		logic report_release;
	} cell_cfg_t;

	typedef struct packed {
		logic scan_accept;
		logic shift;
	} cell_ctrl_t;

endpackage

@@ hw/rtl/mdbr_cell.sv @@
`timescale 1ns / 1ps

module mdbr_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [mdbr_pkg::IDX_W-1:0]         idx,
	input  logic                               level,
	input  mdbr_pkg::cell_cfg_t                cfg,
	input  logic [mdbr_pkg::COUNT_BITS-1:0]    debounce_scans,
	input  logic [mdbr_pkg::COUNT_BITS-1:0]    repeat_scans,
	input  mdbr_pkg::cell_ctrl_t               ctrl,
	input  mdbr_pkg::slot_t                    slot_in,
	input  logic                               any_above,
	output logic                               any_out,
	output mdbr_pkg::slot_t                    slot_out
);

	mdbr_pkg::phase_t                  phase_q, phase_d;
	logic [mdbr_pkg::COUNT_BITS-1:0]   deb_q, deb_d, deb_inc;
	logic [mdbr_pkg::COUNT_BITS-1:0]   rep_q, rep_d, rep_inc;
	logic                              pressed;
	logic                              ev_valid;
	mdbr_pkg::kind_t                   ev_kind;
	mdbr_pkg::slot_t                   slot_q;

	assign pressed = (level == cfg.active_high);
	assign deb_inc = (deb_q == mdbr_pkg::COUNT_MAX) ? deb_q : deb_q + 1'b1;
	assign rep_inc = (rep_q == mdbr_pkg::COUNT_MAX) ? rep_q : rep_q + 1'b1;

	always_comb begin
		phase_d  = phase_q;
		deb_d    = deb_inc;
		rep_d    = rep_inc;
		ev_valid = 1'b0;
		ev_kind  = mdbr_pkg::KIND_PRESSED;
		unique case (phase_q)
			mdbr_pkg::PH_IDLE: begin
				if (pressed) begin
					deb_d   = '0;
					phase_d = mdbr_pkg::PH_PRESS_DEB;
				end
			end
			mdbr_pkg::PH_PRESS_DEB: begin
				if (!pressed) begin
					phase_d = mdbr_pkg::PH_IDLE;
				end else if (deb_inc >= debounce_scans) begin
					phase_d  = mdbr_pkg::PH_PRESSED;
					rep_d    = '0;
					ev_valid = cfg.report_press;
					ev_kind  = mdbr_pkg::KIND_PRESSED;
				end
			end
			mdbr_pkg::PH_PRESSED: begin
				if (!pressed) begin
					deb_d   = '0;
					phase_d = mdbr_pkg::PH_RELEASE_DEB;
				end else if (rep_inc >= repeat_scans) begin
					rep_d    = '0;
					ev_valid = cfg.report_press;
					ev_kind  = mdbr_pkg::KIND_KEPT;
				end
			end
			mdbr_pkg::PH_RELEASE_DEB: begin
				if (pressed) begin
					phase_d = mdbr_pkg::PH_PRESSED;
				end else if (deb_inc >= debounce_scans) begin
					phase_d  = mdbr_pkg::PH_IDLE;
					ev_valid = cfg.report_release;
					ev_kind  = mdbr_pkg::KIND_RELEASED;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mdbr_pkg::PH_IDLE;
			deb_q   <= '0;
			rep_q   <= '0;
		end else if (ctrl.scan_accept) begin
			phase_q <= phase_d;
			deb_q   <= deb_d;
			rep_q   <= rep_d;
		end
	end

	// load this scan's event, else take the slot of the next cell up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (ctrl.scan_accept) begin
			slot_q.valid <= ev_valid;
			slot_q.index <= idx;
			slot_q.kind  <= ev_kind;
			slot_q.last  <= ev_valid & ~any_above;
		end else if (ctrl.shift) begin
			slot_q <= slot_in;
		end
	end

	assign any_out  = ev_valid | any_above;
	assign slot_out = slot_q;

endmodule

@@ hw/rtl/multi_button_debounce_repeat_unit.sv @@
`timescale 1ns / 1ps

// Multi-button debouncer with auto-repeat.
// Slave stream: one request per scan, s_tdata bit i is the raw level of button i.
// Master stream: one request per event, in button order; m_tdata carries the
// button index, m_tuser the event kind (0 pressed, 1 kept pressed, 2 released),
// m_tlast marks the final event of a scan. Scans with no event give nothing.
// APB port: registers active_high_mask, press_report_mask, release_report_mask,
// debounce_scans, repeat_scans at byte addresses 0, 4, 8, 12, 16.
// A row of one cell per button updates all buttons in the accept cycle and
// loads each cell's event slot; the slots then shift one cell per cycle toward
// the output register while it can advance, so the event of button i passes
// through the slots of the lower-index cells. The next scan is accepted once
// the row is empty, that is once the event of the highest button with an event
// has left it; scans without events are accepted every cycle. The output
// register acts as a skid stage: the next scan is taken while the final event
// still waits. When an event waits there and m_tready is low, the row holds.
// Reset sets all buttons idle, counters to zero, masks to zero, debounce_scans to 10 and repeat_scans to 250.

module multi_button_debounce_repeat_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [mdbr_pkg::LEVEL_W-1:0]     s_tdata,   // raw_levels[7:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,   // button_index[2:0], zero pad
	output logic [1:0]                       m_tuser,   // event_kind[1:0]
	output logic                             m_tlast,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mdbr_pkg::ADDR_W-1:0]      paddr,
	input  logic [mdbr_pkg::DATA_W-1:0]      pwdata,
	output logic [mdbr_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);

	logic [mdbr_pkg::MASK_W-1:0]     active_high_q;
	logic [mdbr_pkg::MASK_W-1:0]     press_report_q;
	logic [mdbr_pkg::MASK_W-1:0]     release_report_q;
	logic [mdbr_pkg::COUNT_BITS-1:0] debounce_q;
	logic [mdbr_pkg::COUNT_BITS-1:0] repeat_q;

	mdbr_pkg::reg_idx_t              reg_idx;
	logic                            cfg_write;
	mdbr_pkg::cell_ctrl_t            ctrl;
	mdbr_pkg::slot_t                 slot [mdbr_pkg::BUTTONS];
	mdbr_pkg::slot_t                 out_q;
	logic [mdbr_pkg::BUTTONS-1:0]    slot_busy;
	logic [mdbr_pkg::BUTTONS:0]      any_chain;
	logic                            advance;

	assign pready    = 1'b1;
	assign reg_idx   = mdbr_pkg::reg_idx_t'(paddr[mdbr_pkg::ADDR_W-1:2]);
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_high_q    <= '0;
			press_report_q   <= '0;
			release_report_q <= '0;
			debounce_q       <= mdbr_pkg::DEBOUNCE_DEFAULT;
			repeat_q         <= mdbr_pkg::REPEAT_DEFAULT;
		end else if (cfg_write) begin
			unique case (reg_idx)
				mdbr_pkg::REG_ACTIVE_HIGH:    active_high_q    <= pwdata[mdbr_pkg::MASK_W-1:0];
				mdbr_pkg::REG_PRESS_REPORT:   press_report_q   <= pwdata[mdbr_pkg::MASK_W-1:0];
				mdbr_pkg::REG_RELEASE_REPORT: release_report_q <= pwdata[mdbr_pkg::MASK_W-1:0];
				mdbr_pkg::REG_DEBOUNCE:       debounce_q       <= pwdata[mdbr_pkg::COUNT_BITS-1:0];
				mdbr_pkg::REG_REPEAT:         repeat_q         <= pwdata[mdbr_pkg::COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			mdbr_pkg::REG_ACTIVE_HIGH:    prdata = mdbr_pkg::DATA_W'(active_high_q);
			mdbr_pkg::REG_PRESS_REPORT:   prdata = mdbr_pkg::DATA_W'(press_report_q);
			mdbr_pkg::REG_RELEASE_REPORT: prdata = mdbr_pkg::DATA_W'(release_report_q);
			mdbr_pkg::REG_DEBOUNCE:       prdata = mdbr_pkg::DATA_W'(debounce_q);
			mdbr_pkg::REG_REPEAT:         prdata = mdbr_pkg::DATA_W'(repeat_q);
			default: ;
		endcase
	end

	assign advance          = ~out_q.valid | m_tready;
	assign s_tready         = ~|slot_busy;
	assign ctrl.scan_accept = s_tvalid & s_tready;
	assign ctrl.shift       = advance;
	assign any_chain[mdbr_pkg::BUTTONS] = 1'b0;

	for (genvar i = 0; i < mdbr_pkg::BUTTONS; i++) begin : g_cell
		mdbr_pkg::cell_cfg_t cell_cfg;
		mdbr_pkg::slot_t     slot_up;

		assign cell_cfg.active_high    = active_high_q[i];
		assign cell_cfg.report_press   = press_report_q[i];
		assign cell_cfg.report_release = release_report_q[i];
		assign slot_busy[i]            = slot[i].valid;

		if (i == mdbr_pkg::BUTTONS - 1) begin : g_top
			assign slot_up = '0;
		end else begin : g_mid
			assign slot_up = slot[i+1];
		end

		mdbr_cell u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.idx            (mdbr_pkg::IDX_W'(i)),
			.level          (s_tdata[i]),
			.cfg            (cell_cfg),
			.debounce_scans (debounce_q),
			.repeat_scans   (repeat_q),
			.ctrl           (ctrl),
			.slot_in        (slot_up),
			.any_above      (any_chain[i+1]),
			.any_out        (any_chain[i]),
			.slot_out       (slot[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (advance) begin
			out_q <= slot[0];
		end
	end

	assign m_tvalid = out_q.valid;
	assign m_tdata  = 8'(out_q.index);
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;

endmodule
